FILE: rtl/core/adts_header_parser_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef ADTS_HEADER_PARSER_MACROS_SVH
`define ADTS_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ADTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adts_header_parser: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ADTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adts_header_parser: next-cycle check failed");

`endif

FILE: rtl/core/adts_hp_pkg.sv
package adts_hp_pkg;

    localparam int HDR_BITS  = 56;
    localparam int HDR_BYTES = 7;
    localparam int OUT_BITS  = 83;
    localparam int OUT_TDATA = 88;

    localparam logic [11:0] SYNC_WORD = 12'hFFF;

    typedef enum logic [1:0] {
        ST_PARSED = 2'd0,
        ST_TRUNC  = 2'd1,
        ST_NOSYNC = 2'd2
    } t_status;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
        logic [16:0] rate;
        unique case (idx)
            4'd0:    rate = 17'd96000;
            4'd1:    rate = 17'd88200;
            4'd2:    rate = 17'd64000;
            4'd3:    rate = 17'd48000;
            4'd4:    rate = 17'd44100;
            4'd5:    rate = 17'd32000;
            4'd6:    rate = 17'd24000;
            4'd7:    rate = 17'd22050;
            4'd8:    rate = 17'd16000;
            4'd9:    rate = 17'd12000;
            4'd10:   rate = 17'd11025;
            4'd11:   rate = 17'd8000;
            4'd12:   rate = 17'd7350;
            default: rate = 17'd0;
        endcase
        return rate;
    endfunction

endpackage

FILE: rtl/core/adts_hp_front.sv
module adts_hp_front import adts_hp_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output logic [HDR_BITS-1:0]   o_hdr,
    output logic [COUNT_BITS-1:0] o_cnt
);

    localparam logic [COUNT_BITS-1:0] CntMax = '1;

    logic [HDR_BITS-1:0]   r_hdr, n_hdr;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  w_take;

    assign o_ready = !i_q_stat.full;
    assign w_take  = i_valid && o_ready;

    // Header register only takes the first seven bytes; the count saturates.
    always_comb begin
        n_hdr = (r_cnt < COUNT_BITS'(HDR_BYTES)) ? {r_hdr[HDR_BITS-9:0], i_byte} : r_hdr;
        n_cnt = (r_cnt == CntMax) ? r_cnt : r_cnt + 1'b1;
    end

    assign o_push = w_take && i_last;
    assign o_hdr  = n_hdr;
    assign o_cnt  = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
            r_cnt <= '0;
        end else if (w_take) begin
            if (i_last) begin
                r_hdr <= '0;
                r_cnt <= '0;
            end else begin
                r_hdr <= n_hdr;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

FILE: rtl/core/adts_hp_queue.sv
module adts_hp_queue import adts_hp_pkg::*; #(
    parameter int WIDTH = 72
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_fill;

    assign o_stat.full  = (r_fill == 2'd2);
    assign o_stat.valid = (r_fill != 2'd0);
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/core/adts_hp_back.sv
module adts_hp_back import adts_hp_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_stat               i_q_stat,
    input  logic [HDR_BITS-1:0]   i_hdr,
    input  logic [COUNT_BITS-1:0] i_cnt,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_TDATA-1:0]  o_data
);

    logic                 r_valid;
    logic [OUT_BITS-1:0]  r_data, n_data;
    logic                 w_take;
    logic [32:0]          w_cnt_ext;
    logic [15:0]          w_plen;
    logic [3:0]           w_idx;
    logic [12:0]          w_flen;
    logic [16:0]          w_rate;
    logic [2:0]           w_warn;
    logic [6:0]           w_bits;
    t_status              w_status;

    assign w_take = !r_valid || i_ready;
    assign o_pop  = i_q_stat.valid && w_take;

    always_comb begin
        w_cnt_ext = 33'(i_cnt);
        w_plen    = (w_cnt_ext > 33'h0_FFFF) ? 16'hFFFF : w_cnt_ext[15:0];
        w_idx     = i_hdr[37:34];
        w_flen    = i_hdr[25:13];
        w_rate    = rate_lookup(w_idx);
        w_bits    = {i_hdr[26], i_hdr[27], i_hdr[28], i_hdr[29],
                     i_hdr[33], i_hdr[40], i_hdr[43]};
        w_warn[0] = (i_hdr[42:41] != 2'd0);
        w_warn[1] = (w_idx >= 4'd13);
        w_warn[2] = (w_flen < 13'(HDR_BYTES)) || (33'(w_flen) > w_cnt_ext);

        if (w_cnt_ext < 33'(HDR_BYTES)) begin
            w_status = ST_TRUNC;
        end else if (i_hdr[55:44] != SYNC_WORD) begin
            w_status = ST_NOSYNC;
        end else begin
            w_status = ST_PARSED;
        end

        n_data = '0;
        n_data[82:67] = w_plen;
        n_data[1:0]   = w_status;
        if (w_status == ST_PARSED) begin
            n_data[3:2]   = i_hdr[42:41];
            n_data[5:4]   = i_hdr[39:38];
            n_data[9:6]   = w_idx;
            n_data[26:10] = w_rate;
            n_data[29:27] = i_hdr[32:30];
            n_data[42:30] = w_flen;
            n_data[53:43] = i_hdr[12:2];
            n_data[56:54] = 3'(i_hdr[1:0]) + 3'd1;
            n_data[63:57] = w_bits;
            n_data[66:64] = w_warn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= i_q_stat.valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(OUT_TDATA - OUT_BITS){1'b0}}, r_data};

endmodule

FILE: rtl/core/adts_header_parser.sv
// Channel | Dir | Payload                                   | Transfer rule
// s_axis  | in  | tdata: data_byte[7:0]; tlast: last_byte   | tvalid && tready
// m_axis  | out | tdata: decoded header result (83 bits)    | tvalid && tready
//
// One byte is taken per cycle while the queue is not full; the front keeps the
// header shift register and the byte counter and only needs a queue slot to
// accept bytes. A result passes from its last byte into the two-entry queue and
// then through the decode stage into the output register. Reset is synchronous
// and active low; it clears the counter, header register, queue pointers and
// output valid. A stalled output only blocks the input once two finished
// packets are already waiting in the queue.
`include "adts_header_parser_macros.svh"

module adts_header_parser import adts_hp_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input byte stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // last_byte
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] status, [3:2] layer, [5:4] profile, [9:6] rate_index,
    // [26:10] sample_rate_hz, [29:27] channel_config, [42:30] frame_length,
    // [53:43] buffer_fullness, [56:54] raw_blocks, [63:57] header_bits,
    // [66:64] warnings, [82:67] packet_length, [87:83] zero
    output logic [OUT_TDATA-1:0] m_axis_tdata
);

    localparam int RecBits = HDR_BITS + COUNT_BITS;

    t_q_stat               w_q_stat;
    logic                  w_push;
    logic                  w_pop;
    logic [HDR_BITS-1:0]   w_front_hdr;
    logic [COUNT_BITS-1:0] w_front_cnt;
    logic [RecBits-1:0]    w_q_out;

    // Front: accepts bytes, builds the header and length of each packet.
    adts_hp_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_hdr    (w_front_hdr),
        .o_cnt    (w_front_cnt)
    );

    // Short queue of finished packet records between front and back.
    adts_hp_queue #(
        .WIDTH (RecBits)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_cnt, w_front_hdr}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_q_stat)
    );

    // Back: decodes one record per cycle into the output register while not stalled.
    adts_hp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_hdr    (w_q_out[HDR_BITS-1:0]),
        .i_cnt    (w_q_out[RecBits-1:HDR_BITS]),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

    // A result that is not parsed carries only status and length.
    `ADTS_ASSERT_IMPL(a_unparsed_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] != ST_PARSED), m_axis_tdata[66:2] == '0)
    // A truncated packet is shorter than a header.
    `ADTS_ASSERT_IMPL(a_trunc_short, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] == ST_TRUNC), m_axis_tdata[82:67] < 16'(HDR_BYTES))
    // Raw block count is nonzero exactly for parsed headers.
    `ADTS_ASSERT_IMPL(a_raw_blocks, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[56:54] != 3'd0) == (m_axis_tdata[1:0] == ST_PARSED))
    // The reserved-rate warning matches a zero table rate on parsed headers.
    `ADTS_ASSERT_IMPL(a_rate_warn, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] == ST_PARSED), m_axis_tdata[65] == (m_axis_tdata[26:10] == 17'd0))

endmodule
